[hdl/fsmmr_pkg.sv]
// ============================================================================
// fsmmr_pkg
// Shared widths, constants and register indexes for the frame stacking block.
// ============================================================================
package fsmmr_pkg;

    localparam int SAMPLE_W       = 20;  // signed input sample
    localparam int COADD_W        = 28;  // signed Q20.8 coadded value
    localparam int RMS_W          = 29;  // unsigned Q21.8 RMS value
    localparam int SQ_W           = 58;  // width of a squared deviation
    localparam int FRAC_W         = 8;   // fraction bits of the outputs
    localparam int MAX_FRAMES_DEF = 64;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_USE_MEDIAN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RMS_ENABLE = 8'd1;

endpackage

[hdl/frame_stack_mean_median_rms.sv]
// ============================================================================
// frame_stack_mean_median_rms
// Coadds one pixel's samples across the frames of a cube: mean or median,
// with an optional RMS deviation, in Q20.8 fixed point.
// ============================================================================
// Each input beat carries one frame's sample of the current pixel; tlast marks
// the final frame. A beat without tlast is stored and the block is ready
// again on the next cycle. Up to MAX_FRAMES samples are kept in an internal
// memory; further samples are dropped and the overflow flag in tuser of the
// result is raised. The tlast beat starts the sequencer, which holds s_tready
// low until the result beat has been taken. With the mean selected, a shared
// restoring divider divides the scaled sum by the count. The median is found by
// selection over the memory, one entry read per cycle: each candidate is
// counted against every stored sample, and an even count needs two passes.
// The RMS path adds the squared deviation sweep through the multiplier, the
// divider again, and the square root unit. Configuration writes take effect
// at once and are meant for when the block is idle.
// ============================================================================
module frame_stack_mean_median_rms #(
    parameter int MAX_FRAMES = fsmmr_pkg::MAX_FRAMES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: [19:0] sample
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fsmmr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tlast,
    // m_tdata: [27:0] coadded_value, [56:28] rms_value, rest zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fsmmr_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: [0] overflow
    output logic [fsmmr_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [fsmmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsmmr_pkg::CFG_DAT_W-1:0] cfg_data
);
    import fsmmr_pkg::*;

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int ACC_W  = SQ_W + CNT_W;
    localparam int DIFF_W = COADD_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_MEAN, S_SEL_CAND, S_SEL_WAIT, S_SEL_SCAN, S_SEL_EVAL,
        S_RMS_SCAN, S_RMS_DIV, S_SQRT, S_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic                        use_median_reg, use_median_next;
    logic                        rms_en_reg, rms_en_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic                        ovf_reg, ovf_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic                        ovf_out_reg, ovf_out_next;
    logic signed [COADD_W-1:0]   c_reg, c_next;
    logic [RMS_W-1:0]            rms_reg, rms_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            o_reg, o_next;
    logic                        rd_vld_reg, rd_vld_next;
    logic signed [SAMPLE_W-1:0]  cand_reg, cand_next;
    logic signed [SAMPLE_W-1:0]  lowmid_reg, lowmid_next;
    logic [CNT_W-1:0]            lt_reg, lt_next;
    logic [CNT_W-1:0]            le_reg, le_next;
    logic [CNT_W-1:0]            k_reg, k_next;
    logic                        second_reg, second_next;
    logic                        pair_reg, pair_next;
    logic                        neg_reg, neg_next;
    logic [DIFF_W-1:0]           ad_reg, ad_next;
    logic                        ad_vld_reg, ad_vld_next;
    logic [SQ_W-1:0]             prod_reg, prod_next;
    logic                        prod_vld_reg, prod_vld_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    // Sample memory, one write and one registered read port.
    logic signed [SAMPLE_W-1:0]  mem [MAX_FRAMES];
    logic signed [SAMPLE_W-1:0]  rd_q_reg;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        mem_we;

    logic                        s_accept;
    logic                        store_ok;
    logic signed [SAMPLE_W-1:0]  s_sample;
    logic [CNT_W-1:0]            cnt_after;
    logic signed [SUM_W-1:0]     sum_after;
    logic [SUM_W-1:0]            sum_abs;

    logic                        div_start;
    logic [ACC_W-1:0]            div_dvd;
    logic [CNT_W-1:0]            div_dvs;
    logic                        div_done;
    logic [ACC_W-1:0]            div_quo;
    logic                        sqrt_start;
    logic                        sqrt_done;
    logic [RMS_W-1:0]            sqrt_root;

    logic [COADD_W-1:0]          mean_mag;
    logic signed [SAMPLE_W:0]    mid_sum;
    logic signed [DIFF_W-1:0]    diff;
    logic                        sel_hit;

    assign s_sample  = signed'(s_tdata[SAMPLE_W-1:0]);
    assign s_accept  = s_tvalid && s_tready;
    assign store_ok  = cnt_reg < CNT_W'(MAX_FRAMES);
    assign cnt_after = store_ok ? cnt_reg + 1'b1 : cnt_reg;
    assign sum_after = store_ok ? sum_reg + SUM_W'(s_sample) : sum_reg;
    assign sum_abs   = sum_after[SUM_W-1] ? -sum_after : sum_after;
    assign mem_we    = s_accept && store_ok;
    assign rd_addr   = (state_reg == S_SEL_CAND) ? o_reg[ADDR_W-1:0]
                                                 : idx_reg[ADDR_W-1:0];

    assign mean_mag  = div_quo[COADD_W-1:0];
    assign mid_sum   = (SAMPLE_W+1)'(lowmid_reg) + (SAMPLE_W+1)'(cand_reg);
    // The scaled sample is sign extended before the coadded value is taken off.
    assign diff      = DIFF_W'(signed'({rd_q_reg, {FRAC_W{1'b0}}})) - DIFF_W'(c_reg);
    assign sel_hit   = (lt_reg <= k_reg) && (k_reg < le_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg[ADDR_W-1:0]] <= s_sample;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        use_median_next = use_median_reg;
        rms_en_next     = rms_en_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        ovf_next        = ovf_reg;
        n_next          = n_reg;
        ovf_out_next    = ovf_out_reg;
        c_next          = c_reg;
        rms_next        = rms_reg;
        idx_next        = idx_reg;
        o_next          = o_reg;
        rd_vld_next     = 1'b0;
        cand_next       = cand_reg;
        lowmid_next     = lowmid_reg;
        lt_next         = lt_reg;
        le_next         = le_reg;
        k_next          = k_reg;
        second_next     = second_reg;
        pair_next       = pair_reg;
        neg_next        = neg_reg;
        ad_next         = ad_reg;
        ad_vld_next     = 1'b0;
        prod_next       = ad_reg * ad_reg;
        prod_vld_next   = 1'b0;
        acc_next        = acc_reg;
        m_tvalid_next   = m_tvalid_reg;
        div_start       = 1'b0;
        div_dvd         = ACC_W'({sum_abs, {FRAC_W{1'b0}}});
        div_dvs         = cnt_after;
        sqrt_start      = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_USE_MEDIAN: use_median_next = cfg_data[0];
                REG_RMS_ENABLE: rms_en_next     = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (!s_tlast) begin
                        cnt_next = cnt_after;
                        sum_next = sum_after;
                        ovf_next = ovf_reg || !store_ok;
                    end else begin
                        n_next       = cnt_after;
                        ovf_out_next = ovf_reg || !store_ok;
                        rms_next     = '0;
                        cnt_next     = '0;
                        sum_next     = '0;
                        ovf_next     = 1'b0;
                        if (use_median_reg) begin
                            // Odd count: one pass for the middle rank.
                            // Even count: the lower middle first, then the upper.
                            k_next      = (cnt_after - 1'b1) >> 1;
                            second_next = !cnt_after[0];
                            pair_next   = !cnt_after[0];
                            o_next      = '0;
                            state_next  = S_SEL_CAND;
                        end else begin
                            neg_next   = sum_after[SUM_W-1];
                            div_start  = 1'b1;
                            state_next = S_MEAN;
                        end
                    end
                end
            end
            S_MEAN: begin
                if (div_done) begin
                    c_next = neg_reg ? -signed'(mean_mag) : signed'(mean_mag);
                    if (rms_en_reg) begin
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = S_RMS_SCAN;
                    end else begin
                        m_tvalid_next = 1'b1;
                        state_next    = S_OUT;
                    end
                end
            end
            S_SEL_CAND: begin
                state_next = S_SEL_WAIT;
            end
            S_SEL_WAIT: begin
                cand_next  = rd_q_reg;
                idx_next   = '0;
                lt_next    = '0;
                le_next    = '0;
                state_next = S_SEL_SCAN;
            end
            S_SEL_SCAN: begin
                if (idx_reg < n_reg) begin
                    idx_next    = idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg) begin
                    lt_next = lt_reg + CNT_W'(rd_q_reg < cand_reg);
                    le_next = le_reg + CNT_W'(rd_q_reg <= cand_reg);
                end else if (idx_reg == n_reg) begin
                    state_next = S_SEL_EVAL;
                end
            end
            S_SEL_EVAL: begin
                if (!sel_hit) begin
                    o_next     = o_reg + 1'b1;
                    state_next = S_SEL_CAND;
                end else if (second_reg) begin
                    lowmid_next = cand_reg;
                    second_next = 1'b0;
                    k_next      = k_reg + 1'b1;
                    o_next      = '0;
                    state_next  = S_SEL_CAND;
                end else begin
                    c_next = pair_reg ? COADD_W'({mid_sum, 7'b0})
                                      : COADD_W'({cand_reg, {FRAC_W{1'b0}}});
                    if (rms_en_reg) begin
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = S_RMS_SCAN;
                    end else begin
                        m_tvalid_next = 1'b1;
                        state_next    = S_OUT;
                    end
                end
            end
            S_RMS_SCAN: begin
                // Read, absolute deviation, square and accumulate stages.
                if (idx_reg < n_reg) begin
                    idx_next    = idx_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                ad_next       = diff[DIFF_W-1] ? -diff : diff;
                ad_vld_next   = rd_vld_reg;
                prod_vld_next = ad_vld_reg;
                if (prod_vld_reg) begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (idx_reg == n_reg && !rd_vld_reg && !ad_vld_reg && !prod_vld_reg) begin
                    div_start  = 1'b1;
                    div_dvd    = acc_reg;
                    div_dvs    = n_reg;
                    state_next = S_RMS_DIV;
                end
            end
            S_RMS_DIV: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    rms_next      = sqrt_root;
                    m_tvalid_next = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            use_median_reg <= 1'b0;
            rms_en_reg     <= 1'b0;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
            rd_vld_reg     <= 1'b0;
            ad_vld_reg     <= 1'b0;
            prod_vld_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            use_median_reg <= use_median_next;
            rms_en_reg     <= rms_en_next;
            cnt_reg        <= cnt_next;
            sum_reg        <= sum_next;
            ovf_reg        <= ovf_next;
            rd_vld_reg     <= rd_vld_next;
            ad_vld_reg     <= ad_vld_next;
            prod_vld_reg   <= prod_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        n_reg       <= n_next;
        ovf_out_reg <= ovf_out_next;
        c_reg       <= c_next;
        rms_reg     <= rms_next;
        idx_reg     <= idx_next;
        o_reg       <= o_next;
        cand_reg    <= cand_next;
        lowmid_reg  <= lowmid_next;
        lt_reg      <= lt_next;
        le_reg      <= le_next;
        k_reg       <= k_next;
        second_reg  <= second_next;
        pair_reg    <= pair_next;
        neg_reg     <= neg_next;
        ad_reg      <= ad_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
    end

    fsmmr_div #(
        .DVD_W(ACC_W),
        .DVS_W(CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    fsmmr_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quo[SQ_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({rms_reg, c_reg});
    assign m_tuser  = ovf_out_reg;
endmodule

[hdl/fsmmr_div.sv]
// ============================================================================
// fsmmr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module fsmmr_div #(
    parameter int DVD_W = 68,
    parameter int DVS_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVD_W-1:0] quo_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
                quo_reg  <= {quo_reg[DVD_W-2:0], ge};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

[hdl/fsmmr_sqrt.sv]
// ============================================================================
// fsmmr_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ============================================================================
module fsmmr_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fsmmr_pkg::SQ_W-1:0]  radicand,
    output logic                        done,
    output logic [fsmmr_pkg::RMS_W-1:0] root
);
    import fsmmr_pkg::*;

    localparam int STEP_W = $clog2(RMS_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [RMS_W+1:0]  rem_reg;
    logic [SQ_W-1:0]   val_reg;
    logic [RMS_W-1:0]  root_reg;

    logic [RMS_W+1:0]  shifted;
    logic [RMS_W+1:0]  trial;
    logic              ge;

    assign shifted = {rem_reg[RMS_W-1:0], val_reg[SQ_W-1:SQ_W-2]};
    assign trial   = {root_reg, 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                val_reg  <= radicand;
                root_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= ge ? (shifted - trial) : shifted;
                val_reg  <= {val_reg[SQ_W-3:0], 2'b00};
                root_reg <= {root_reg[RMS_W-2:0], ge};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(RMS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

[hdl/fsmmr_checker.sv]
// ============================================================================
// fsmmr_checker
// Port-level checks of the frame stacking block, bound to its top level.
// ============================================================================
module fsmmr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [fsmmr_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fsmmr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [fsmmr_pkg::M_TUSER_W-1:0] m_tuser
);
    import fsmmr_pkg::*;

    // A result is never shown in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The block takes no sample while a result waits.
    a_busy_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // After a sample that does not end the pixel, the block is ready again in the next cycle.
    a_store_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("not ready after a plain sample beat");

    // A stalled result holds its payload.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A waiting input beat stays on the bus unchanged.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("stalled input beat changed");
endmodule

bind frame_stack_mean_median_rms fsmmr_checker u_fsmmr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[dv/tb_frame_stack_mean_median_rms.sv]
// ============================================================================
// tb_frame_stack_mean_median_rms
// Self-checking bench for the frame stacking block (mean/median with RMS).
// ============================================================================
// Pixels are sent as runs of sample beats, the final beat marked by tlast.
// Every accepted input beat is folded into a local copy of the pixel state;
// on a tlast beat the expected coadded value, RMS and overflow flag are
// computed and queued. The result stream is compared field by field against
// the oldest queued pixel. The run walks through every register setting,
// including writes to unused register indexes, with random idling on both
// sides except in the final phase.
// ============================================================================
module tb_frame_stack_mean_median_rms;
    timeunit 1ns;
    timeprecision 1ps;
    import fsmmr_pkg::*;

    localparam int DEPTH       = MAX_FRAMES_DEF;
    localparam int STALL_LIMIT = 60000;
    localparam int SETTLE      = 64;
    localparam logic signed [SAMPLE_W-1:0] SMAX = 20'sh7FFFF;
    localparam logic signed [SAMPLE_W-1:0] SMIN = 20'sh80000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } beat_t;

    typedef struct packed {
        logic signed [COADD_W-1:0] coadd;
        logic [RMS_W-1:0]          rms;
        logic                      ovf;
    } pixel_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    // Work queues shared between the sequence, the driver and the checker.
    beat_t         pending_beats[$];
    pixel_result_t expected_pixels[$];
    int            beats_open = 0;   // queued beats not yet accepted

    // Local copy of the block's pixel state and registers.
    int  stack_samples[DEPTH];
    int  stack_count = 0;
    bit  stack_dropped = 0;
    bit  median_mode = 0;
    bit  rms_mode = 0;

    int  errors = 0;
    int  stall_cycles = 0;
    bit  quiet = 0;   // no idling on either side in the final phase
    int  src_gap = 0;
    int  sink_gap = 0;

    frame_stack_mean_median_rms u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Folds one accepted beat into the pixel state; on the final frame the
    // coadded result is queued and the state clears for the next pixel.
    function automatic void stack_beat(logic signed [SAMPLE_W-1:0] s, logic last);
        int              srt[DEPTH];
        int              v;
        int              j;
        longint          total;
        longint          coadd;
        longint          d;
        longint unsigned sq;
        longint unsigned rms;
        pixel_result_t   r;
        if (stack_count < DEPTH) begin
            stack_samples[stack_count] = s;
            stack_count++;
        end else begin
            stack_dropped = 1;
        end
        if (!last) return;
        if (median_mode) begin
            for (int i = 0; i < stack_count; i++) begin
                v = stack_samples[i];
                j = i;
                while (j > 0 && srt[j-1] > v) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = v;
            end
            if (stack_count % 2 == 1)
                coadd = longint'(srt[stack_count/2]) * 256;
            else
                coadd = (longint'(srt[stack_count/2-1]) + longint'(srt[stack_count/2])) * 128;
        end else begin
            total = 0;
            for (int i = 0; i < stack_count; i++) total += stack_samples[i];
            // SystemVerilog signed division truncates toward zero.
            coadd = (total * 256) / longint'(stack_count);
        end
        rms = 0;
        if (rms_mode) begin
            sq = 0;
            for (int i = 0; i < stack_count; i++) begin
                d = longint'(stack_samples[i]) * 256 - coadd;
                if (d < 0) d = -d;
                sq += longint'(unsigned'(d)) * longint'(unsigned'(d));
            end
            rms = isqrt(sq / longint'(unsigned'(stack_count)));
        end
        r.coadd = coadd[COADD_W-1:0];
        r.rms   = rms[RMS_W-1:0];
        r.ovf   = stack_dropped;
        expected_pixels.push_back(r);
        stack_count = 0;
        stack_dropped = 0;
    endfunction

    // Input side: predicts on each accepted beat, then presents the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                beats_open--;
                stack_beat($signed(s_tdata[SAMPLE_W-1:0]), s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    src_gap <= $urandom_range(0, 15);
                    s_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    s_tdata  <= {{(S_TDATA_W-SAMPLE_W){1'b0}}, pending_beats[0].sample};
                    s_tlast  <= pending_beats[0].last;
                    s_tvalid <= 1'b1;
                    void'(pending_beats.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: checks each accepted beat and stalls in random bursts.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result beat, actual tdata=%h tuser=%h",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    if (m_tdata[COADD_W-1:0] !== expected_pixels[0].coadd) begin
                        $display("%0t: coadded_value expected %0d actual %0d", $time,
                                 expected_pixels[0].coadd, $signed(m_tdata[COADD_W-1:0]));
                        errors++;
                    end
                    if (m_tdata[COADD_W+RMS_W-1:COADD_W] !== expected_pixels[0].rms) begin
                        $display("%0t: rms_value expected %0d actual %0d", $time,
                                 expected_pixels[0].rms, m_tdata[COADD_W+RMS_W-1:COADD_W]);
                        errors++;
                    end
                    if (m_tdata[M_TDATA_W-1:COADD_W+RMS_W] !== '0) begin
                        $display("%0t: tdata padding expected 0 actual %h", $time,
                                 m_tdata[M_TDATA_W-1:COADD_W+RMS_W]);
                        errors++;
                    end
                    if (m_tuser[0] !== expected_pixels[0].ovf) begin
                        $display("%0t: overflow expected %0b actual %0b", $time,
                                 expected_pixels[0].ovf, m_tuser[0]);
                        errors++;
                    end
                    void'(expected_pixels.pop_front());
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: the median of a full store can keep both sides quiet for two full
    // selection passes plus the RMS path, so the limit sits well above that.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return SMAX;
            1:       return SMIN;
            2:       return SAMPLE_W'($urandom_range(0, 16) - 8);
            3:       return SAMPLE_W'($urandom_range(0, 2000) - 1000);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic void queue_pixel(int frames);
        beat_t b;
        for (int i = 0; i < frames; i++) begin
            b.sample = pick_sample();
            b.last   = (i == frames - 1);
            pending_beats.push_back(b);
            beats_open++;
        end
    endfunction

    function automatic void queue_random(int beats);
        int sent;
        int frames;
        sent = 0;
        while (sent < beats) begin
            // Mostly short pixels; now and then one that nearly fills, fills or overruns the store.
            if ($urandom_range(0, 39) == 0)
                frames = $urandom_range(DEPTH - 4, DEPTH + 6);
            else
                frames = $urandom_range(1, 12);
            queue_pixel(frames);
            sent += frames;
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_USE_MEDIAN) median_mode = val;
        else if (idx == REG_RMS_ENABLE) rms_mode = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every queued beat has been accepted and every result has
    // come out, then lets the block settle before registers may change.
    task automatic drain();
        while (beats_open > 0 || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic void push_beat(logic signed [SAMPLE_W-1:0] s, logic last);
        beat_t b;
        b.sample = s;
        b.last   = last;
        pending_beats.push_back(b);
        beats_open++;
    endfunction

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pixels under every register setting: single extremes, a
        // mixed pair (even median), odd and even runs, and all-negative data.
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_USE_MEDIAN, m[0]);
            write_reg(REG_RMS_ENABLE, m[1]);
            push_beat(SMAX, 1'b1);
            push_beat(SMIN, 1'b1);
            push_beat(SMAX, 1'b0);
            push_beat(SMIN, 1'b1);
            push_beat(20'sd5, 1'b0);
            push_beat(-20'sd3, 1'b0);
            push_beat(20'sd7, 1'b1);
            push_beat(-20'sd1, 1'b0);
            push_beat(-20'sd2, 1'b0);
            push_beat(-20'sd2, 1'b0);
            push_beat(-20'sd9, 1'b1);
            push_beat(SMIN, 1'b0);
            push_beat(SMIN, 1'b0);
            push_beat(SMIN, 1'b1);
            drain();
        end

        // The store filling exactly, then overrunning with the tlast beat dropped.
        write_reg(REG_USE_MEDIAN, 1'b1);
        write_reg(REG_RMS_ENABLE, 1'b1);
        queue_pixel(DEPTH);
        queue_pixel(DEPTH + 1);
        drain();
        write_reg(REG_USE_MEDIAN, 1'b0);
        queue_pixel(DEPTH + 3);
        drain();

        // Writes to unused indexes must leave both registers alone.
        write_reg(8'd2, 1'b0);
        write_reg(8'd255, 1'b0);
        queue_random(40);
        drain();

        // Random phases over all settings; the last runs without idling.
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_USE_MEDIAN, p[0]);
            write_reg(REG_RMS_ENABLE, p[1]);
            if (p == 7) quiet = 1;
            queue_random(200);
            drain();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[frame_stack_mean_median_rms.f]
hdl/fsmmr_pkg.sv
hdl/fsmmr_div.sv
hdl/fsmmr_sqrt.sv
hdl/frame_stack_mean_median_rms.sv
hdl/fsmmr_checker.sv
dv/tb_frame_stack_mean_median_rms.sv
